// ===== rtl/evsd_pkg.sv =====
// Shared types and constants for the EMA velocity surge detector.
// Used by evsd_ema, evsd_trend and ema_velocity_surge_detector; no dependencies.
package evsd_pkg;

	localparam int SampleW   = 16;
	localparam int AlphaW    = 16;
	localparam int ThreshW   = 32;
	localparam int MinW      = 16;
	localparam int AvgW      = 32;
	localparam int VelW      = 33;
	localparam int AccW      = 34;
	localparam int CountW    = 32;
	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 32;

	// Register indexes of the configuration port.
	localparam logic [CfgIndexW-1:0] CFG_SMOOTHING = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_MIN_SAMP  = 2'd2;

	localparam logic [AlphaW-1:0]  ALPHA_RESET   = 16'd6554;
	localparam logic [ThreshW-1:0] THRESH_RESET  = 32'd214748365;
	localparam logic [MinW-1:0]    MIN_SAMP_RESET = 16'd1;

	localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

	// Packed result word width, rounded up to whole bytes.
	localparam int ResultBits = AvgW + VelW + AccW + 2 + 3 * CountW;
	localparam int OutDataW   = ((ResultBits + 7) / 8) * 8;

	typedef struct packed {
		logic [AlphaW-1:0]  smoothing_factor;
		logic [ThreshW-1:0] velocity_limit;
		logic [MinW-1:0]    warmup_length;
	} evsd_cfg_t;

	typedef struct packed {
		logic [CountW-1:0]      sample_count;
		logic [CountW-1:0]      negative_count;
		logic [CountW-1:0]      positive_count;
		logic                   negative_surge;
		logic                   positive_surge;
		logic signed [AccW-1:0] acceleration;
		logic signed [VelW-1:0] velocity;
		logic signed [AvgW-1:0] average;
	} evsd_result_t;

endpackage

// ===== rtl/ema_velocity_surge_detector.sv =====
// Top level of the EMA velocity surge detector: stream ports, configuration
// registers and the two-stage pipeline. Depends on evsd_pkg, evsd_ema, evsd_trend.
//
// The block takes one signed Q1.15 sample per input word and returns one result
// word per sample: the exponential moving average (Q1.31), its velocity and
// acceleration, two surge flags and three saturating counters. The first sample
// after reset seeds the average directly; later samples move it by
// alpha * (sample - average), floored. A surge is flagged once the sample count,
// counting the current sample, reaches the warm-up length, when the velocity is
// strictly above the threshold (positive) or strictly below its negative (negative).
// Throughput is one sample per clock while the master side takes every result word.
// Each sample is registered first in the average, then in the result word on the
// master side: the first stage is the average update (one 33 x 17 multiply in the
// average feedback loop), the second computes the differences, compares and
// counters and holds the result word. While the result word waits, an empty first
// stage can still take one sample and then holds it; the slave side stays ready
// as long as the first stage is empty or can move. Configuration is written
// through cfg_wen, cfg_index and cfg_wdata and takes effect on the next accepted
// sample; index 3 is ignored. Write configuration only while no sample is in flight.
module ema_velocity_surge_detector import evsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_wen,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata,
	// Sample stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [SampleW-1:0]   s_axis_tdata,   // [15:0] sample
	// Result stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [31:0] average, [64:32] velocity, [98:65] acceleration, [99] positive_surge,
	// [100] negative_surge, [132:101] positive_count, [164:133] negative_count,
	// [196:165] sample_count, [199:197] zero
	output logic [OutDataW-1:0]  m_axis_tdata
);

	evsd_cfg_t              cfg_q;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   accept;
	logic                   advance;
	logic                   out_free;
	logic signed [AvgW-1:0] avg_s1;
	evsd_result_t           res_q;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_factor <= ALPHA_RESET;
			cfg_q.velocity_limit   <= THRESH_RESET;
			cfg_q.warmup_length    <= MIN_SAMP_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SMOOTHING: cfg_q.smoothing_factor <= cfg_wdata[AlphaW-1:0];
				CFG_THRESHOLD: cfg_q.velocity_limit   <= cfg_wdata[ThreshW-1:0];
				CFG_MIN_SAMP:  cfg_q.warmup_length    <= cfg_wdata[MinW-1:0];
				default: begin
				end
			endcase
		end
	end

	// The result register can load when it is empty or being drained this cycle.
	// The first stage can load when it is empty or moving into the result register.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	evsd_ema u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (s_axis_tdata),
		.alpha  (cfg_q.smoothing_factor),
		.avg_s1 (avg_s1)
	);

	evsd_trend u_trend (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.avg_s1  (avg_s1),
		.cfg     (cfg_q),
		.res_q   (res_q)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OutDataW-ResultBits){1'b0}}, res_q};

endmodule

// ===== rtl/evsd_ema.sv =====
// Moving-average update stage: holds the running average and the seed flag.
// Depends on evsd_pkg.
module evsd_ema import evsd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic signed [SampleW-1:0] sample,
	input  logic [AlphaW-1:0]        alpha,
	output logic signed [AvgW-1:0]   avg_s1
);

	logic                       seeded_q;
	logic signed [AvgW-1:0]     target;
	logic signed [AvgW:0]       diff;
	logic signed [AvgW+AlphaW+1:0] product;
	logic signed [AvgW+1:0]     step;
	logic signed [AvgW+1:0]     next_avg;

	// The sample enters the average as sample * 2^16; the product shift floors.
	assign target   = {sample, {(AvgW-SampleW){1'b0}}};
	assign diff     = {target[AvgW-1], target} - {avg_s1[AvgW-1], avg_s1};
	assign product  = diff * $signed({1'b0, alpha});
	assign step     = product[AvgW+AlphaW+1:AlphaW];
	assign next_avg = {{2{avg_s1[AvgW-1]}}, avg_s1} + step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			avg_s1   <= '0;
		end else if (accept) begin
			seeded_q <= 1'b1;
			if (!seeded_q) begin
				avg_s1 <= target;
			end else begin
				avg_s1 <= next_avg[AvgW-1:0];
			end
		end
	end

endmodule

// ===== rtl/evsd_trend.sv =====
// Slope stage: velocity, acceleration, surge tests and saturating counters.
// Depends on evsd_pkg; the result register also holds the previous step's values.
module evsd_trend import evsd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic signed [AvgW-1:0] avg_s1,
	input  evsd_cfg_t              cfg,
	output evsd_result_t           res_q
);

	logic signed [VelW-1:0] vel;
	logic signed [AccW-1:0] acc;
	logic signed [AccW-1:0] vel_wide;
	logic signed [AccW-1:0] thr_pos;
	logic signed [AccW-1:0] thr_neg;
	logic [CountW:0]        seen_plus;
	logic                   armed;
	logic                   pos_hit;
	logic                   neg_hit;
	evsd_result_t           res_d;

	assign vel      = {avg_s1[AvgW-1], avg_s1} - {res_q.average[AvgW-1], res_q.average};
	assign acc      = {vel[VelW-1], vel} - {res_q.velocity[VelW-1], res_q.velocity};
	assign vel_wide = {vel[VelW-1], vel};
	assign thr_pos  = $signed({2'b00, cfg.velocity_limit});
	assign thr_neg  = -thr_pos;

	// Warm-up counts the current sample, even once the count has saturated.
	assign seen_plus = {1'b0, res_q.sample_count} + {{CountW{1'b0}}, 1'b1};
	assign armed     = seen_plus >= {{(CountW+1-MinW){1'b0}}, cfg.warmup_length};
	assign pos_hit   = armed && (vel_wide > thr_pos);
	assign neg_hit   = armed && !pos_hit && (vel_wide < thr_neg);

	always_comb begin
		res_d                = res_q;
		res_d.average        = avg_s1;
		res_d.velocity       = vel;
		res_d.acceleration   = acc;
		res_d.positive_surge = pos_hit;
		res_d.negative_surge = neg_hit;
		if (pos_hit && res_q.positive_count != COUNT_MAX) begin
			res_d.positive_count = res_q.positive_count + 1'b1;
		end
		if (neg_hit && res_q.negative_count != COUNT_MAX) begin
			res_d.negative_count = res_q.negative_count + 1'b1;
		end
		if (res_q.sample_count != COUNT_MAX) begin
			res_d.sample_count = res_q.sample_count + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (advance) begin
			res_q <= res_d;
		end
	end

endmodule
